### rtl/core/ppes_pkg.sv
// Shared types and constants for the primitive path entanglement statistics block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ppes_pkg;

  localparam int MAX_MOLECULES_DEF = 1024;
  localparam int COORD_WIDTH_DEF   = 32;

  localparam int ID_W       = 11;
  localparam int CNT_W      = 11;
  localparam int ACC_W      = 48;
  localparam int LEN_W      = 48;
  localparam int R2_W       = 63;
  localparam int OUT_W      = 48;
  localparam int WIDE_W     = 128;
  localparam int DEN_W      = 64;
  localparam int DIV_CNT_W  = 8;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [0:0] REG_MOLECULE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    SEL_DX, SEL_DY, SEL_DZ, SEL_MX, SEL_MY, SEL_MZ
  } mac_sel_t;

  typedef enum logic [1:0] {
    DIV_R2, DIV_LEN, DIV_A, DIV_Z
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     acc_clr;
    logic     mac_start;
    mac_sel_t mac_sel;
    logic     sqrt_start;
    logic     rd_bond;
    logic     bond_wr;
    logic     walk_init;
    logic     rd_walk;
    logic     lsum_add;
    logic     idx_inc;
    logic     idx_clr;
    logic     clr_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_deg;
  } ppes_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic sqrt_busy;
    logic div_busy;
    logic id_ok;
    logic last;
    logic n_zero;
    logic idx_last_walk;
    logic idx_last_clr;
    logic len_zero;
    logic a_zero;
  } ppes_status_t;

endpackage

### rtl/core/ppes_if.sv
// Valid/ready channel interfaces for bond beats and result beats.
// Depends on ppes_pkg for field widths.
interface ppes_bond_if import ppes_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic [ID_W-1:0]               molecule_id;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic                          last_bond;

  modport source (output valid, molecule_id, first_x, first_y, first_z,
                  second_x, second_y, second_z, last_bond, input ready);
  modport sink (input valid, molecule_id, first_x, first_y, first_z,
                second_x, second_y, second_z, last_bond, output ready);
endinterface

interface ppes_stats_if import ppes_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  entanglement_count;
  logic [OUT_W-1:0]  step_length;
  logic [R2_W-1:0]   mean_sq_end_to_end;
  logic [OUT_W-1:0]  mean_contour_length;
  logic              degenerate;

  modport source (output valid, entanglement_count, step_length, mean_sq_end_to_end,
                  mean_contour_length, degenerate, input ready);
  modport sink (input valid, entanglement_count, step_length, mean_sq_end_to_end,
                mean_contour_length, degenerate, output ready);
endinterface

### rtl/core/ppes_dpath.sv
// Datapath: per-molecule accumulator memory, serial square-accumulate unit,
// digit-serial square root and bit-serial divider. Depends on ppes_pkg.
module ppes_dpath import ppes_pkg::*; #(
  parameter int MAX_MOLECULES = MAX_MOLECULES_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppes_cmd_t                     cmd,
  output ppes_status_t                  status,
  input  logic [CNT_W-1:0]              molecule_count,
  input  logic [ID_W-1:0]               molecule_id,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic                          last_bond,
  output logic [OUT_W-1:0]              entanglement_count,
  output logic [OUT_W-1:0]              step_length,
  output logic [R2_W-1:0]               mean_sq_end_to_end,
  output logic [OUT_W-1:0]              mean_contour_length,
  output logic                          degenerate
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int MW     = (DW > ACC_W) ? DW : ACC_W;
  localparam int SW     = MW + 1;
  localparam int RW     = COORD_WIDTH + 2;
  localparam int LT_W   = ((RW > LEN_W) ? RW : LEN_W) + 1;
  localparam int AW     = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;
  localparam int SCW    = $clog2(RW + 1);
  localparam int WORD_W = 3 * ACC_W + LEN_W;

  logic [ID_W-1:0] id_q;
  logic [DW-1:0]   dx, dy, dz;
  logic            last_q;
  logic [CNT_W-1:0] n_eff;
  logic [ID_W-1:0] k;
  logic [AW-1:0]   addr_bond;
  logic [AW-1:0]   idx;

  logic [WORD_W-1:0] store [MAX_MOLECULES];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] upd_word;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              wr_en, rd_en;
  logic [ACC_W-1:0]  r_vx, r_vy, r_vz;
  logic [LEN_W-1:0]  r_len;
  logic              sat_seen;

  logic [MW-1:0]     mac_m;
  logic [WIDE_W-1:0] mac_add;
  logic [WIDE_W-1:0] acc;
  logic [MW-1:0]     mac_op;

  logic [SCW-1:0]    cnt_s;
  logic [2*RW-1:0]   rad;
  logic [RW+1:0]     srem;
  logic [RW-1:0]     root;
  logic [RW+1:0]     s_rem2, s_trial;
  logic              s_ge;

  logic [DIV_CNT_W-1:0] cnt_d;
  logic [WIDE_W-1:0]    dnum, dq, d_num_in, d_qn;
  logic [DEN_W-1:0]     dden, d_den_in;
  logic [DEN_W:0]       drem, d_rem2;
  logic                 d_ge;
  div_sel_t             dsel;

  logic [DEN_W-1:0]  lsum;
  logic [DEN_W-1:0]  len;
  logic [R2_W-1:0]   r2;
  logic [OUT_W-1:0]  a_val, z_val;

  logic [ACC_W-1:0]  nx, ny, nz;
  logic              ox, oy, oz;
  logic [LT_W-1:0]   tot;
  logic              olen;
  logic [LEN_W-1:0]  nlen;

  function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W-1:0] a_in,
                                               input logic [DW-1:0] d, output logic ovf);
    logic [SW-1:0] s;
    s = {{(SW-ACC_W){a_in[ACC_W-1]}}, a_in} + {{(SW-DW){d[DW-1]}}, d};
    ovf = !((&s[SW-1:ACC_W-1]) || !(|s[SW-1:ACC_W-1]));
    if (ovf) begin
      return s[SW-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic [MW-1:0] mag_d(input logic [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? (~v + DW'(1)) : v;
    return MW'(m);
  endfunction

  function automatic logic [MW-1:0] mag_a(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    return MW'(m);
  endfunction

  always_comb begin
    if (32'(molecule_count) > MAX_MOLECULES) begin
      n_eff = CNT_W'(MAX_MOLECULES);
    end else begin
      n_eff = molecule_count;
    end
  end

  assign k         = id_q - ID_W'(1);
  assign addr_bond = AW'(k);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_q   <= molecule_id;
      last_q <= last_bond;
      dx <= {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
      dy <= {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};
      dz <= {first_z[COORD_WIDTH-1], first_z} - {second_z[COORD_WIDTH-1], second_z};
    end
  end

  assign r_vx  = rdata[ACC_W-1:0];
  assign r_vy  = rdata[2*ACC_W-1:ACC_W];
  assign r_vz  = rdata[3*ACC_W-1:2*ACC_W];
  assign r_len = rdata[WORD_W-1:3*ACC_W];

  always_comb begin
    nx   = acc_sat(r_vx, dx, ox);
    ny   = acc_sat(r_vy, dy, oy);
    nz   = acc_sat(r_vz, dz, oz);
    tot  = LT_W'(r_len) + LT_W'(root);
    olen = tot > LT_W'({LEN_W{1'b1}});
    nlen = olen ? {LEN_W{1'b1}} : tot[LEN_W-1:0];
    upd_word = {nlen, nz, ny, nx};
  end

  assign wr_en   = cmd.bond_wr | cmd.clr_step;
  assign wr_addr = cmd.clr_step ? idx : addr_bond;
  assign wr_data = cmd.clr_step ? '0 : upd_word;
  assign rd_en   = cmd.rd_bond | cmd.rd_walk;
  assign rd_addr = cmd.rd_walk ? idx : addr_bond;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_seen <= 1'b0;
      idx      <= '0;
    end else begin
      if (cmd.clr_step) begin
        sat_seen <= 1'b0;
      end else if (cmd.bond_wr && (ox || oy || oz || olen)) begin
        sat_seen <= 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd.mac_sel)
      SEL_DX:  mac_op = mag_d(dx);
      SEL_DY:  mac_op = mag_d(dy);
      SEL_DZ:  mac_op = mag_d(dz);
      SEL_MX:  mac_op = mag_a(r_vx);
      SEL_MY:  mac_op = mag_a(r_vy);
      SEL_MZ:  mac_op = mag_a(r_vz);
      default: mac_op = '0;
    endcase
  end

  // Shift-add squaring: one multiplier bit per cycle, added into acc.
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_m <= '0;
    end else if (cmd.mac_start) begin
      mac_m <= mac_op;
    end else if (mac_m != '0) begin
      mac_m <= mac_m >> 1;
    end
    if (cmd.mac_start) begin
      mac_add <= WIDE_W'(mac_op);
    end else if (mac_m != '0) begin
      mac_add <= mac_add << 1;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (!cmd.mac_start && mac_m[0]) begin
      acc <= acc + mac_add;
    end
  end

  always_comb begin
    s_rem2  = {srem[RW-1:0], rad[2*RW-1:2*RW-2]};
    s_trial = {root, 2'b01};
    s_ge    = s_rem2 >= s_trial;
  end

  // Square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_s <= '0;
    end else if (cmd.sqrt_start) begin
      cnt_s <= SCW'(RW);
    end else if (cnt_s != '0) begin
      cnt_s <= cnt_s - SCW'(1);
    end
    if (cmd.sqrt_start) begin
      rad  <= acc[2*RW-1:0];
      srem <= '0;
      root <= '0;
    end else if (cnt_s != '0) begin
      rad  <= rad << 2;
      srem <= s_ge ? (s_rem2 - s_trial) : s_rem2;
      root <= {root[RW-2:0], s_ge};
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_R2: begin
        d_num_in = acc;
        d_den_in = DEN_W'(n_eff) << 16;
      end
      DIV_LEN: begin
        d_num_in = WIDE_W'(lsum);
        d_den_in = DEN_W'(n_eff);
      end
      DIV_A: begin
        d_num_in = WIDE_W'(r2) << 16;
        d_den_in = len;
      end
      DIV_Z: begin
        d_num_in = WIDE_W'(len) << 16;
        d_den_in = DEN_W'(a_val);
      end
      default: begin
        d_num_in = '0;
        d_den_in = '0;
      end
    endcase
    d_rem2 = {drem[DEN_W-1:0], dnum[WIDE_W-1]};
    d_ge   = d_rem2 >= {1'b0, dden};
    d_qn   = {dq[WIDE_W-2:0], d_ge};
  end

  // Restoring divider, one quotient bit per cycle; the result lands in its
  // target register on the last step; r2, a_val and z_val saturate, len keeps the low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_d <= '0;
    end else if (cmd.div_start) begin
      cnt_d <= DIV_CNT_W'(WIDE_W);
    end else if (cnt_d != '0) begin
      cnt_d <= cnt_d - DIV_CNT_W'(1);
    end
    if (cmd.div_start) begin
      dnum <= d_num_in;
      dden <= d_den_in;
      drem <= '0;
      dq   <= '0;
      dsel <= cmd.div_sel;
    end else if (cnt_d != '0) begin
      dnum <= dnum << 1;
      drem <= d_ge ? (d_rem2 - {1'b0, dden}) : d_rem2;
      dq   <= d_qn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      lsum <= '0;
    end else if (cmd.lsum_add) begin
      lsum <= lsum + DEN_W'(r_len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      r2         <= '0;
      len        <= '0;
      a_val      <= '0;
      z_val      <= '0;
      degenerate <= sat_seen | (n_eff == '0);
    end else if (cmd.set_deg) begin
      degenerate <= 1'b1;
    end else if (cnt_d == DIV_CNT_W'(1)) begin
      unique case (dsel)
        DIV_R2: begin
          if (d_qn[WIDE_W-1:R2_W] != '0) begin
            r2         <= {R2_W{1'b1}};
            degenerate <= 1'b1;
          end else begin
            r2 <= d_qn[R2_W-1:0];
          end
        end
        DIV_LEN: len <= d_qn[DEN_W-1:0];
        DIV_A: begin
          if (d_qn[WIDE_W-1:OUT_W] != '0) begin
            a_val      <= {OUT_W{1'b1}};
            degenerate <= 1'b1;
          end else begin
            a_val <= d_qn[OUT_W-1:0];
          end
        end
        DIV_Z: begin
          if (d_qn[WIDE_W-1:OUT_W] != '0) begin
            z_val      <= {OUT_W{1'b1}};
            degenerate <= 1'b1;
          end else begin
            z_val <= d_qn[OUT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign entanglement_count  = z_val;
  assign step_length         = a_val;
  assign mean_sq_end_to_end  = r2;
  assign mean_contour_length = len[OUT_W-1:0];

  always_comb begin
    status.mac_busy      = mac_m != '0;
    status.sqrt_busy     = cnt_s != '0;
    status.div_busy      = cnt_d != '0;
    status.id_ok         = (id_q != '0) && (id_q <= n_eff);
    status.last          = last_q;
    status.n_zero        = n_eff == '0;
    status.idx_last_walk = idx == AW'(n_eff - CNT_W'(1));
    status.idx_last_clr  = idx == AW'(MAX_MOLECULES - 1);
    status.len_zero      = len == '0;
    status.a_zero        = a_val == '0;
  end

endmodule

### rtl/core/ppes_ctrl.sv
// Controller: sequences bond accumulation, the molecule walk, the divisions
// and the store clearing pass. Depends on ppes_pkg.
module ppes_ctrl import ppes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ppes_status_t status,
  output ppes_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_WX, S_WY, S_WZ, S_WSQ, S_UPD, S_LAST,
    S_WINIT, S_WNEXT, S_WRD, S_WMX, S_WMY, S_WMZ, S_WDR2, S_WDLEN,
    S_CHKLEN, S_WDA, S_CHKA, S_WDZ, S_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.idx_last_clr) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          cmd.acc_clr = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.id_ok) begin
          cmd.mac_start = 1'b1;
          cmd.mac_sel   = SEL_DX;
          state_next    = S_WX;
        end else begin
          state_next = S_LAST;
        end
      end
      S_WX: begin
        cmd.mac_sel = SEL_DY;
        if (!status.mac_busy) begin
          cmd.mac_start = 1'b1;
          state_next    = S_WY;
        end
      end
      S_WY: begin
        cmd.mac_sel = SEL_DZ;
        if (!status.mac_busy) begin
          cmd.mac_start = 1'b1;
          state_next    = S_WZ;
        end
      end
      S_WZ: begin
        if (!status.mac_busy) begin
          cmd.sqrt_start = 1'b1;
          cmd.rd_bond    = 1'b1;
          state_next     = S_WSQ;
        end
      end
      S_WSQ: begin
        if (!status.sqrt_busy) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.bond_wr = 1'b1;
        state_next  = S_LAST;
      end
      S_LAST: begin
        state_next = status.last ? S_WINIT : S_IDLE;
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        cmd.acc_clr   = 1'b1;
        cmd.idx_clr   = 1'b1;
        state_next    = status.n_zero ? S_OUT : S_WNEXT;
      end
      S_WNEXT: begin
        cmd.rd_walk = 1'b1;
        state_next  = S_WRD;
      end
      S_WRD: begin
        cmd.mac_start = 1'b1;
        cmd.mac_sel   = SEL_MX;
        cmd.lsum_add  = 1'b1;
        state_next    = S_WMX;
      end
      S_WMX: begin
        cmd.mac_sel = SEL_MY;
        if (!status.mac_busy) begin
          cmd.mac_start = 1'b1;
          state_next    = S_WMY;
        end
      end
      S_WMY: begin
        cmd.mac_sel = SEL_MZ;
        if (!status.mac_busy) begin
          cmd.mac_start = 1'b1;
          state_next    = S_WMZ;
        end
      end
      S_WMZ: begin
        cmd.div_sel = DIV_R2;
        if (!status.mac_busy) begin
          if (status.idx_last_walk) begin
            cmd.div_start = 1'b1;
            state_next    = S_WDR2;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_WNEXT;
          end
        end
      end
      S_WDR2: begin
        cmd.div_sel = DIV_LEN;
        if (!status.div_busy) begin
          cmd.div_start = 1'b1;
          state_next    = S_WDLEN;
        end
      end
      S_WDLEN: begin
        if (!status.div_busy) begin
          state_next = S_CHKLEN;
        end
      end
      S_CHKLEN: begin
        cmd.div_sel = DIV_A;
        if (status.len_zero) begin
          cmd.set_deg = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WDA;
        end
      end
      S_WDA: begin
        if (!status.div_busy) begin
          state_next = S_CHKA;
        end
      end
      S_CHKA: begin
        cmd.div_sel = DIV_Z;
        if (status.a_zero) begin
          cmd.set_deg = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WDZ;
        end
      end
      S_WDZ: begin
        if (!status.div_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_CLEAR;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= state_next == S_IDLE;
      out_valid <= state_next == S_OUT;
    end
  end

endmodule

### rtl/core/primitive_path_entanglement_stats.sv
// Top level: entanglement statistics of primitive paths over a bond stream.
// The time a bond takes is set by the serial squarer and the one-bit-per-cycle square root;
// one item is in flight at a time. A last bond adds the molecule walk plus up to four
// divisions, for the mean squared end-to-end distance, mean contour length, step length and
// entanglement count. After reset and after each result beat, a clearing pass zeroes the
// store; no bond is accepted during it, while register writes are taken as ever.
module primitive_path_entanglement_stats import ppes_pkg::*; #(
  parameter int MAX_MOLECULES = MAX_MOLECULES_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ppes_bond_if.sink          bond_in,
  ppes_stats_if.source       stats_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CNT_W-1:0] molecule_count;
  ppes_cmd_t        cmd;
  ppes_status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      molecule_count <= CNT_W'(1);
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1:2] == REG_MOLECULE_COUNT) begin
      molecule_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_MOLECULE_COUNT) begin
      prdata = PDATA_W'(molecule_count);
    end else begin
      prdata = '0;
    end
  end

  ppes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bond_in.valid),
    .in_ready  (bond_in.ready),
    .out_valid (stats_out.valid),
    .out_ready (stats_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ppes_dpath #(
    .MAX_MOLECULES (MAX_MOLECULES),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .molecule_count      (molecule_count),
    .molecule_id         (bond_in.molecule_id),
    .first_x             (bond_in.first_x),
    .first_y             (bond_in.first_y),
    .first_z             (bond_in.first_z),
    .second_x            (bond_in.second_x),
    .second_y            (bond_in.second_y),
    .second_z            (bond_in.second_z),
    .last_bond           (bond_in.last_bond),
    .entanglement_count  (stats_out.entanglement_count),
    .step_length         (stats_out.step_length),
    .mean_sq_end_to_end  (stats_out.mean_sq_end_to_end),
    .mean_contour_length (stats_out.mean_contour_length),
    .degenerate          (stats_out.degenerate)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(bond_in.ready && stats_out.valid))
    else $error("bond accepted while a result is pending");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    stats_out.valid && stats_out.ready |=> !bond_in.ready)
    else $error("bond accepted before the clearing pass");

  a_zero_len_degenerate: assert property (@(posedge clk) disable iff (rst)
    stats_out.valid && stats_out.mean_contour_length == '0 |-> stats_out.degenerate)
    else $error("zero contour length not flagged");

  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    stats_out.valid && stats_out.step_length == '0 |-> stats_out.entanglement_count == '0)
    else $error("entanglement count without step length");

endmodule
